// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define TCPQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tcpq assertion failed");

// Clocked assertion, checked during reset too.
`define TCPQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("tcpq assertion failed");

`endif

// File: hw/rtl/tcpq_pkg.sv
package tcpq_pkg;

   localparam logic [2:0] FUNC_ENQ    = 3'd0;
   localparam logic [2:0] FUNC_DEQ    = 3'd1;
   localparam logic [2:0] FUNC_MARK   = 3'd2;
   localparam logic [2:0] FUNC_REMOVE = 3'd3;
   localparam logic [2:0] FUNC_AGE    = 3'd4;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   localparam logic [6:0] RESET_SENIOR_AGE = 7'd60;
   localparam logic [15:0] RESET_WAIT_LIMIT = 16'd120;

   localparam logic CSR_SENIOR_AGE = 1'b0;
   localparam logic CSR_WAIT_LIMIT = 1'b1;

   // class masks: bit 0 emergency, bit 1 priority, bit 2 normal
   localparam logic [2:0] CLASS_EMERG  = 3'b001;
   localparam logic [2:0] CLASS_PRIO   = 3'b010;
   localparam logic [2:0] CLASS_NORMAL = 3'b100;

   typedef struct packed {
      logic [15:0] tkt;
      logic [15:0] arrive;
      logic        prio;
      logic        emerg;
   } entry_type;

   typedef struct packed {
      logic      keep;
      logic      hit;
      entry_type ent;
   } pass_res_type;

   function automatic logic [2:0] pass_mask(input logic [2:0] op, input logic [1:0] ps);
      logic [2:0] m;
      m = CLASS_NORMAL;
      case (op)
         FUNC_ENQ:                 m = (ps == 2'd0) ? (CLASS_EMERG | CLASS_PRIO) : CLASS_NORMAL;
         FUNC_DEQ, FUNC_REMOVE:    m = CLASS_EMERG | CLASS_PRIO | CLASS_NORMAL;
         default: begin
            case (ps)
               2'd0:    m = CLASS_EMERG;
               2'd1:    m = CLASS_PRIO;
               default: m = CLASS_NORMAL;
            endcase
         end
      endcase
      return m;
   endfunction

   function automatic logic [1:0] last_pass(input logic [2:0] op);
      logic [1:0] p;
      case (op)
         FUNC_ENQ:              p = 2'd1;
         FUNC_DEQ, FUNC_REMOVE: p = 2'd0;
         default:               p = 2'd2;
      endcase
      return p;
   endfunction

endpackage

// File: hw/rtl/tcpq_mem.sv
module tcpq_mem #(
   parameter int AW = 7
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  tcpq_pkg::entry_type   wr_data,
   input  logic [AW-1:0]         rd_addr,
   output tcpq_pkg::entry_type   rd_data
);

   tcpq_pkg::entry_type mem [2**AW];
   tcpq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/tcpq_pass.sv
module tcpq_pass #(
   parameter int IW = 6
) (
   input  tcpq_pkg::entry_type    ent,
   input  logic [IW-1:0]          idx,
   input  logic [2:0]             op,
   input  logic [2:0]             mask,
   input  logic [15:0]            tkt,
   input  logic [15:0]            now,
   input  logic [15:0]            wait_limit,
   input  logic                   found,
   input  logic [IW-1:0]          pos,
   output tcpq_pkg::pass_res_type res
);

   logic [15:0] wait_time;
   logic        hit;
   logic        em;
   logic        pr;
   logic [2:0]  cls;
   logic        skip;

   always_comb begin
      wait_time = now - ent.arrive;
      case (op)
         tcpq_pkg::FUNC_DEQ:                       hit = (idx == '0);
         tcpq_pkg::FUNC_REMOVE, tcpq_pkg::FUNC_MARK:
            hit = found ? (idx == pos) : (ent.tkt == tkt);
         default:                                  hit = 1'b0;
      endcase
      em = ent.emerg | ((op == tcpq_pkg::FUNC_MARK) & hit);
      pr = ent.prio | ((op == tcpq_pkg::FUNC_AGE) & (wait_time > wait_limit));
      cls = em ? tcpq_pkg::CLASS_EMERG : (pr ? tcpq_pkg::CLASS_PRIO : tcpq_pkg::CLASS_NORMAL);
      skip = (op == tcpq_pkg::FUNC_DEQ) | (op == tcpq_pkg::FUNC_REMOVE);
      res.keep = (|(cls & mask)) & ~(skip & hit);
      res.hit = hit;
      res.ent.tkt = ent.tkt;
      res.ent.arrive = ent.arrive;
      res.ent.prio = pr;
      res.ent.emerg = em;
   end

endmodule

// File: hw/rtl/three_class_priority_queue_unit.sv
// Three-class ticket queue (emergency, priority, normal; FIFO within a class).
// Commands enter on start while busy is low and each gives one result beat on
// rsp_valid, one cycle wide, which cannot be stalled. Entries live in one
// memory with two banks and a single read port; reordering copies the live
// bank into the other one entry per cycle, keeping a class filter per pass.
// Enqueue of a normal entry, dequeue of an empty queue, a full enqueue and
// unused codes run no pass. Dequeue and remove take one pass, a priority
// enqueue two passes with an insert step between, mark and aging check three
// passes, each framed by the accept and the result state; a remove or mark
// whose ticket is not found ends after the first pass.
// No clearing pass after reset: only entries below the count are read.
module three_class_priority_queue_unit #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [15:0] req_ticket,
   input  logic [6:0]  req_age,
   input  logic        req_health_worker,
   input  logic [15:0] req_time_now,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_ticket_out,
   output logic        rsp_was_priority,
   output logic        rsp_was_emergency,
   output logic [6:0]  rsp_occupancy,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = IW + 1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_PASS = 4'b0010,
      S_INS  = 4'b0100,
      S_RESP = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic          bank_ff, bank_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] iss_ff, iss_in;
   logic [CW-1:0] n_ff, n_in;
   logic          v_ff, v_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          found_ff, found_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic [1:0]    ps_ff, ps_in;
   logic [2:0]    op_ff, op_in;
   logic [15:0]   tkt_ff, tkt_in;
   logic [15:0]   now_ff, now_in;
   logic          prio_ff, prio_in;
   logic [1:0]    status_ff, status_in;
   logic [15:0]   tout_ff, tout_in;
   logic          out_pr_ff, out_pr_in;
   logic          out_em_ff, out_em_in;
   logic [6:0]    senior_ff, senior_in;
   logic [15:0]   limit_ff, limit_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   tcpq_pkg::entry_type    wr_data;
   tcpq_pkg::entry_type    rd_data;
   tcpq_pkg::entry_type    new_ent;
   tcpq_pkg::pass_res_type res;
   logic [2:0]             mask;
   logic                   req_prio;
   logic                   pass_done;

   tcpq_mem #(.AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr ({bank_ff, iss_ff[IW-1:0]}),
      .rd_data (rd_data)
   );

   tcpq_pass #(.IW(IW)) u_pass (
      .ent        (rd_data),
      .idx        (idx_ff),
      .op         (op_ff),
      .mask       (mask),
      .tkt        (tkt_ff),
      .now        (now_ff),
      .wait_limit (limit_ff),
      .found      (found_ff),
      .pos        (pos_ff),
      .res        (res)
   );

   assign mask      = tcpq_pkg::pass_mask(op_ff, ps_ff);
   assign req_prio  = (req_age >= senior_ff) | req_health_worker;
   assign pass_done = (state_ff == S_PASS) & (iss_ff == count_ff) & ~v_ff;

   always_comb begin
      state_in  = state_ff;
      bank_in   = bank_ff;
      count_in  = count_ff;
      iss_in    = iss_ff;
      n_in      = n_ff;
      v_in      = 1'b0;
      idx_in    = idx_ff;
      found_in  = found_ff;
      pos_in    = pos_ff;
      ps_in     = ps_ff;
      op_in     = op_ff;
      tkt_in    = tkt_ff;
      now_in    = now_ff;
      prio_in   = prio_ff;
      status_in = status_ff;
      tout_in   = tout_ff;
      out_pr_in = out_pr_ff;
      out_em_in = out_em_ff;
      senior_in = senior_ff;
      limit_in  = limit_ff;
      wr_en     = 1'b0;
      wr_addr   = {~bank_ff, n_ff[IW-1:0]};
      new_ent.tkt    = tkt_ff;
      new_ent.arrive = now_ff;
      new_ent.prio   = prio_ff;
      new_ent.emerg  = 1'b0;
      wr_data   = new_ent;

      if (csr_we) begin
         if (csr_index == tcpq_pkg::CSR_SENIOR_AGE) begin
            senior_in = csr_wdata[6:0];
         end else begin
            limit_in = csr_wdata;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = req_func;
               tkt_in    = req_ticket;
               now_in    = req_time_now;
               prio_in   = req_prio;
               found_in  = 1'b0;
               n_in      = '0;
               iss_in    = '0;
               ps_in     = 2'd0;
               status_in = tcpq_pkg::STATUS_OK;
               tout_in   = '0;
               out_pr_in = 1'b0;
               out_em_in = 1'b0;
               state_in  = S_PASS;
               case (req_func)
                  tcpq_pkg::FUNC_ENQ: begin
                     if (count_ff >= CW'(QUEUE_DEPTH)) begin
                        status_in = tcpq_pkg::STATUS_FULL;
                        state_in  = S_RESP;
                     end else if (!req_prio) begin
                        wr_en          = 1'b1;
                        wr_addr        = {bank_ff, count_ff[IW-1:0]};
                        wr_data.tkt    = req_ticket;
                        wr_data.arrive = req_time_now;
                        wr_data.prio   = 1'b0;
                        wr_data.emerg  = 1'b0;
                        count_in       = count_ff + 1'b1;
                        state_in       = S_RESP;
                     end
                  end
                  tcpq_pkg::FUNC_DEQ: begin
                     if (count_ff == '0) begin
                        status_in = tcpq_pkg::STATUS_EMPTY;
                        state_in  = S_RESP;
                     end
                  end
                  tcpq_pkg::FUNC_MARK, tcpq_pkg::FUNC_REMOVE, tcpq_pkg::FUNC_AGE: begin
                     state_in = S_PASS;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_PASS: begin
            if (iss_ff < count_ff) begin
               v_in   = 1'b1;
               idx_in = iss_ff[IW-1:0];
               iss_in = iss_ff + 1'b1;
            end
            if (v_ff) begin
               if (res.keep) begin
                  wr_en   = 1'b1;
                  wr_data = res.ent;
                  n_in    = n_ff + 1'b1;
               end
               if (res.hit && !found_ff) begin
                  found_in = 1'b1;
                  pos_in   = idx_ff;
                  if (op_ff != tcpq_pkg::FUNC_MARK) begin
                     tout_in   = rd_data.tkt;
                     out_pr_in = rd_data.prio;
                     out_em_in = rd_data.emerg;
                  end
               end
            end
            if (pass_done) begin
               if ((op_ff == tcpq_pkg::FUNC_REMOVE || op_ff == tcpq_pkg::FUNC_MARK)
                   && !found_ff) begin
                  status_in = tcpq_pkg::STATUS_NOT_FOUND;
                  state_in  = S_RESP;
               end else if (ps_ff == tcpq_pkg::last_pass(op_ff)) begin
                  bank_in  = ~bank_ff;
                  count_in = n_ff;
                  state_in = S_RESP;
               end else if (op_ff == tcpq_pkg::FUNC_ENQ) begin
                  state_in = S_INS;
               end else begin
                  ps_in  = ps_ff + 1'b1;
                  iss_in = '0;
               end
            end
         end
         S_INS: begin
            wr_en    = 1'b1;
            n_in     = n_ff + 1'b1;
            ps_in    = 2'd1;
            iss_in   = '0;
            state_in = S_PASS;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         bank_ff   <= 1'b0;
         count_ff  <= '0;
         v_ff      <= 1'b0;
         senior_ff <= tcpq_pkg::RESET_SENIOR_AGE;
         limit_ff  <= tcpq_pkg::RESET_WAIT_LIMIT;
      end else begin
         state_ff  <= state_in;
         bank_ff   <= bank_in;
         count_ff  <= count_in;
         v_ff      <= v_in;
         senior_ff <= senior_in;
         limit_ff  <= limit_in;
      end
      iss_ff    <= iss_in;
      n_ff      <= n_in;
      idx_ff    <= idx_in;
      found_ff  <= found_in;
      pos_ff    <= pos_in;
      ps_ff     <= ps_in;
      op_ff     <= op_in;
      tkt_ff    <= tkt_in;
      now_ff    <= now_in;
      prio_ff   <= prio_in;
      status_ff <= status_in;
      tout_ff   <= tout_in;
      out_pr_ff <= out_pr_in;
      out_em_ff <= out_em_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = (state_ff == S_RESP);
   assign rsp_status        = status_ff;
   assign rsp_ticket_out    = tout_ff;
   assign rsp_was_priority  = out_pr_ff;
   assign rsp_was_emergency = out_em_ff;
   assign rsp_occupancy     = 7'(count_ff);

endmodule

// File: hw/rtl/tcpq_checker.sv
`include "assert_macros.svh"

module tcpq_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_ticket_out
);

   `TCPQ_ASSERT(a_rsp_while_busy, clock, reset, rsp_valid |-> busy)
   `TCPQ_ASSERT(a_accept_goes_busy, clock, reset, (start && !busy) |=> busy)
   `TCPQ_ASSERT(a_rsp_one_beat, clock, reset, rsp_valid |=> !rsp_valid)
   `TCPQ_ASSERT(a_err_no_ticket, clock, reset,
      (rsp_valid && rsp_status != tcpq_pkg::STATUS_OK) |-> (rsp_ticket_out == 16'd0))
   `TCPQ_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !busy)

endmodule

bind three_class_priority_queue_unit tcpq_checker u_tcpq_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_ticket_out (rsp_ticket_out)
);
